FILE: sv/motor_feedback_decode_filter_defines.svh
// ----------------------------------------------------------------------------
// Motor feedback decode filter assertion macros
// Shared assertion forms for the checker of the feedback decoder.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_DECODE_FILTER_DEFINES_SVH
`define MOTOR_FEEDBACK_DECODE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFDF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mfdf_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback decode filter package
// Types and constants shared by the feedback decoder modules.
// ----------------------------------------------------------------------------
package mfdf_pkg;

    localparam logic [8:0] MOTOR_COUNT   = 9'd8;
    localparam logic [8:0] TOGGLE_PERIOD = 9'd500;

    localparam logic [47:0] PI_Q46      = 48'hC90FDAA22169;
    localparam logic [23:0] PI_HI       = PI_Q46[47:24];
    localparam logic [23:0] PI_LO       = PI_Q46[23:0];
    localparam logic [63:0] ANGLE_ROUND = 64'h0000_0200_0000_0000;

    localparam int ADDR_W = 3;
    localparam logic REG_MOTOR_NUMBER = 1'b0;
    localparam logic REG_ID_BASE      = 1'b1;

    localparam logic [7:0]  MOTOR_NUMBER_RESET = 8'd1;
    localparam logic [10:0] ID_BASE_RESET      = 11'd512;

    typedef struct packed {
        logic [7:0]  motor_number;
        logic [10:0] feedback_id_base;
    } t_cfg;

    typedef struct packed {
        logic               frame_matched;
        logic [15:0]        angle_raw;
        logic signed [15:0] speed_raw;
        logic signed [15:0] current_raw;
        logic [7:0]         temperature;
        logic signed [27:0] speed_radps;
        logic [2:0]         indicator_toggle;
        logic [39:0]        ang_hi_prod;
        logic [39:0]        ang_lo_prod;
    } t_mid;

endpackage

FILE: sv/mfdf_frame_if.sv
// ----------------------------------------------------------------------------
// Feedback frame channel
// Valid/ready channel that carries one received feedback frame per word.
// ----------------------------------------------------------------------------
interface mfdf_frame_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_ident;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;

    modport source (
        output valid, frame_ident, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        input  ready
    );

    modport sink (
        input  valid, frame_ident, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        output ready
    );
endinterface

FILE: sv/mfdf_result_if.sv
// ----------------------------------------------------------------------------
// Decoded feedback channel
// Valid/ready channel that carries one decoded feedback result per word.
// ----------------------------------------------------------------------------
interface mfdf_result_if;
    logic               valid;
    logic               ready;
    logic               frame_matched;
    logic [15:0]        angle_raw;
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
    logic [7:0]         temperature;
    logic [21:0]        angle_radians;
    logic signed [27:0] speed_radps;
    logic [2:0]         indicator_toggle;

    modport source (
        output valid, frame_matched, angle_raw, speed_raw, current_raw, temperature,
               angle_radians, speed_radps, indicator_toggle,
        input  ready
    );

    modport sink (
        input  valid, frame_matched, angle_raw, speed_raw, current_raw, temperature,
               angle_radians, speed_radps, indicator_toggle,
        output ready
    );
endinterface

FILE: sv/motor_feedback_decode_filter.sv
// ----------------------------------------------------------------------------
// Motor feedback decode filter
// Decodes motor feedback frames and low-pass filters speed for motors 0 to 7.
// ----------------------------------------------------------------------------
// Every frame word yields exactly one result word after the input, decode
// and result registers, and a new frame is taken in every cycle in which
// the result register is empty or its word is being taken. The speed filter
// closes its recurrence in the decode stage, so throughput is one frame per
// clock while results are taken; the angle conversion product is split
// across the decode and output stages. Frames match when the identifier
// minus the base, modulo 256, equals the motor number; a match updates the
// held values and match counter; every 500th match pulses the indicator mask.
module motor_feedback_decode_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mfdf_frame_if.sink                  i_frame,
    mfdf_result_if.source               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfdf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    mfdf_pkg::t_cfg cfg;
    mfdf_pkg::t_mid mid;
    logic           mid_valid;
    logic           advance;

    mfdf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mfdf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (i_frame),
        .i_cfg       (cfg),
        .i_advance   (advance),
        .o_mid_valid (mid_valid),
        .o_mid       (mid)
    );

    mfdf_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_advance   (advance),
        .o_result    (o_result)
    );

endmodule

FILE: sv/mfdf_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the motor number and the identifier base.
// ----------------------------------------------------------------------------
module mfdf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfdf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mfdf_pkg::t_cfg              o_cfg
);

    logic [7:0]  r_motor_number;
    logic [10:0] r_id_base;
    logic        wr_en;
    logic        sel;

    assign sel    = paddr[2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_number <= mfdf_pkg::MOTOR_NUMBER_RESET;
            r_id_base      <= mfdf_pkg::ID_BASE_RESET;
        end else if (wr_en) begin
            case (sel)
                mfdf_pkg::REG_MOTOR_NUMBER: r_motor_number <= pwdata[7:0];
                mfdf_pkg::REG_ID_BASE:      r_id_base      <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            mfdf_pkg::REG_MOTOR_NUMBER: prdata = {24'd0, r_motor_number};
            mfdf_pkg::REG_ID_BASE:      prdata = {21'd0, r_id_base};
            default:                    prdata = 32'd0;
        endcase
    end

    assign o_cfg.motor_number     = r_motor_number;
    assign o_cfg.feedback_id_base = r_id_base;

endmodule

FILE: sv/mfdf_core.sv
// ----------------------------------------------------------------------------
// Feedback decode core
// Input register, frame match, held values, match counter and speed filter.
// ----------------------------------------------------------------------------
module mfdf_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mfdf_frame_if.sink     i_frame,
    input  mfdf_pkg::t_cfg i_cfg,
    input  logic           i_advance,
    output logic           o_mid_valid,
    output mfdf_pkg::t_mid o_mid
);

    logic               r_in_valid;
    logic [10:0]        r_ident;
    logic [15:0]        r_angle_in;
    logic [15:0]        r_speed_in;
    logic [15:0]        r_current_in;
    logic [7:0]         r_temp_in;

    logic [15:0]        r_held_angle;
    logic signed [15:0] r_held_speed;
    logic signed [15:0] r_held_current;
    logic [7:0]         r_held_temp;
    logic [8:0]         r_count;
    logic signed [27:0] r_filt;

    logic               r_mid_valid;
    mfdf_pkg::t_mid     r_mid;

    logic               match;
    logic [15:0]        n_held_angle;
    logic signed [15:0] n_held_speed;
    logic signed [15:0] n_held_current;
    logic [7:0]         n_held_temp;
    logic [8:0]         count_inc;
    logic               wrap;
    logic [8:0]         n_count;
    logic [2:0]         toggle;
    logic signed [27:0] raw_speed;
    logic signed [45:0] acc;
    logic signed [27:0] filt_new;
    logic               bypass;
    logic signed [27:0] n_filt;
    mfdf_pkg::t_mid     n_mid;

    function automatic logic [2:0] toggle_mask(input logic [7:0] motor);
        case (motor)
            8'd1:    toggle_mask = 3'b001;
            8'd2:    toggle_mask = 3'b010;
            8'd3:    toggle_mask = 3'b100;
            8'd4:    toggle_mask = 3'b111;
            default: toggle_mask = 3'b000;
        endcase
    endfunction

    assign i_frame.ready = i_advance;

    always_comb begin
        match          = (r_ident[7:0] - i_cfg.feedback_id_base[7:0]) == i_cfg.motor_number;
        n_held_angle   = match ? r_angle_in : r_held_angle;
        n_held_speed   = match ? $signed(r_speed_in) : r_held_speed;
        n_held_current = match ? $signed(r_current_in) : r_held_current;
        n_held_temp    = match ? r_temp_in : r_held_temp;

        count_inc = match ? r_count + 9'd1 : r_count;
        wrap      = count_inc == mfdf_pkg::TOGGLE_PERIOD;
        n_count   = wrap ? 9'd0 : count_inc;
        toggle    = wrap ? toggle_mask(i_cfg.motor_number) : 3'b000;

        raw_speed = 28'(32'(n_held_speed) * 32'sd2560);
        acc       = 46'(r_filt) * 46'sd13107
                  + 46'(n_held_speed) * 46'sd134218240
                  + 46'sd32768;
        filt_new  = acc[43:16];
        bypass    = {1'b0, i_cfg.motor_number} >= mfdf_pkg::MOTOR_COUNT;
        n_filt    = bypass ? r_filt : filt_new;

        n_mid.frame_matched    = match;
        n_mid.angle_raw        = n_held_angle;
        n_mid.speed_raw        = n_held_speed;
        n_mid.current_raw      = n_held_current;
        n_mid.temperature      = n_held_temp;
        n_mid.speed_radps      = bypass ? raw_speed : filt_new;
        n_mid.indicator_toggle = toggle;
        n_mid.ang_hi_prod      = n_held_angle * mfdf_pkg::PI_HI;
        n_mid.ang_lo_prod      = n_held_angle * mfdf_pkg::PI_LO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_mid_valid    <= 1'b0;
            r_held_angle   <= '0;
            r_held_speed   <= '0;
            r_held_current <= '0;
            r_held_temp    <= '0;
            r_count        <= '0;
            r_filt         <= '0;
        end else if (i_advance) begin
            r_in_valid  <= i_frame.valid;
            r_mid_valid <= r_in_valid;
            if (r_in_valid) begin
                r_held_angle   <= n_held_angle;
                r_held_speed   <= n_held_speed;
                r_held_current <= n_held_current;
                r_held_temp    <= n_held_temp;
                r_count        <= n_count;
                r_filt         <= n_filt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_ident      <= i_frame.frame_ident;
            r_angle_in   <= {i_frame.byte0, i_frame.byte1};
            r_speed_in   <= {i_frame.byte2, i_frame.byte3};
            r_current_in <= {i_frame.byte4, i_frame.byte5};
            r_temp_in    <= i_frame.byte6;
            r_mid        <= n_mid;
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

endmodule

FILE: sv/mfdf_out.sv
// ----------------------------------------------------------------------------
// Output stage
// Final angle conversion sum and the result register of the output channel.
// ----------------------------------------------------------------------------
module mfdf_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mid_valid,
    input  mfdf_pkg::t_mid i_mid,
    output logic           o_advance,
    mfdf_result_if.source  o_result
);

    logic               r_valid;
    logic               r_matched;
    logic [15:0]        r_angle_raw;
    logic signed [15:0] r_speed_raw;
    logic signed [15:0] r_current_raw;
    logic [7:0]         r_temperature;
    logic [21:0]        r_angle_radians;
    logic signed [27:0] r_speed_radps;
    logic [2:0]         r_toggle;
    logic [63:0]        angle_sum;

    assign o_advance = !r_valid || o_result.ready;

    assign angle_sum = {i_mid.ang_hi_prod, 24'd0} + {24'd0, i_mid.ang_lo_prod}
                     + mfdf_pkg::ANGLE_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_matched       <= i_mid.frame_matched;
            r_angle_raw     <= i_mid.angle_raw;
            r_speed_raw     <= i_mid.speed_raw;
            r_current_raw   <= i_mid.current_raw;
            r_temperature   <= i_mid.temperature;
            r_angle_radians <= angle_sum[63:42];
            r_speed_radps   <= i_mid.speed_radps;
            r_toggle        <= i_mid.indicator_toggle;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.frame_matched    = r_matched;
    assign o_result.angle_raw        = r_angle_raw;
    assign o_result.speed_raw        = r_speed_raw;
    assign o_result.current_raw      = r_current_raw;
    assign o_result.temperature      = r_temperature;
    assign o_result.angle_radians    = r_angle_radians;
    assign o_result.speed_radps      = r_speed_radps;
    assign o_result.indicator_toggle = r_toggle;

endmodule

FILE: sv/mfdf_checker.sv
// ----------------------------------------------------------------------------
// Feedback decoder checker
// Port-level assertions for the feedback decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_feedback_decode_filter_defines.svh"

module mfdf_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_matched,
    input logic [27:0] i_speed,
    input logic [2:0]  i_toggle
);

    logic        stall;
    logic        empty;
    logic        pulse;
    logic        known;
    logic [31:0] word;

    assign stall = i_out_valid && !i_out_ready;
    assign empty = !i_out_valid;
    assign pulse = i_out_valid && (i_toggle != 3'b000);
    assign known = i_toggle inside {3'b001, 3'b010, 3'b100, 3'b111};
    assign word  = {i_out_valid, i_speed, i_toggle};

    `MFDF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stall, $stable(word), "Stalled word changed")
    `MFDF_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, empty, i_in_ready, "Frame refused when empty")
    `MFDF_ASSERT_IMPL(a_toggle_match, i_clk, i_rst_n, pulse, i_matched, "Pulse on unmatched frame")
    `MFDF_ASSERT_IMPL(a_toggle_mask, i_clk, i_rst_n, pulse, known, "Unknown indicator mask")

endmodule

bind motor_feedback_decode_filter mfdf_port_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_frame.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_matched   (o_result.frame_matched),
    .i_speed     (o_result.speed_radps),
    .i_toggle    (o_result.indicator_toggle)
);

FILE: tb/sv/mfdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback decoder checker
// Watches the frame, result and register ports of the feedback decoder, keeps
// its own copy of the decoder state, predicts every result word and compares
// it field by field with the word that leaves the block.
// ----------------------------------------------------------------------------
module mfdf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mfdf_frame_if                       i_frame,
    mfdf_result_if                      i_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfdf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam logic [mfdf_pkg::ADDR_W-1:0] ADDR_MOTOR_NUMBER =
        {mfdf_pkg::REG_MOTOR_NUMBER, 2'b00};
    localparam logic [mfdf_pkg::ADDR_W-1:0] ADDR_ID_BASE =
        {mfdf_pkg::REG_ID_BASE, 2'b00};

    localparam logic [2:0] MASK_NONE  = 3'b000;
    localparam logic [2:0] MASK_BLUE  = 3'b001;
    localparam logic [2:0] MASK_GREEN = 3'b010;
    localparam logic [2:0] MASK_RED   = 3'b100;
    localparam logic [2:0] MASK_ALL   = 3'b111;

    typedef struct packed {
        logic        frame_matched;
        logic [15:0] angle_raw;
        logic [15:0] speed_raw;
        logic [15:0] current_raw;
        logic [7:0]  temperature;
        logic [21:0] angle_radians;
        logic [27:0] speed_radps;
        logic [2:0]  indicator_toggle;
    } t_decoded;

    logic [7:0]         motor_num;
    logic [10:0]        id_base;
    logic [15:0]        held_angle;
    logic signed [15:0] held_speed;
    logic [15:0]        held_current;
    logic [7:0]         held_temp;
    logic [8:0]         match_count;
    logic signed [27:0] filt_speed;

    t_decoded expected_q[$];
    int       fail_total;
    int       word_index;

    function automatic logic [2:0] toggle_mask(input logic [7:0] motor);
        case (motor)
            8'd1:    return MASK_BLUE;
            8'd2:    return MASK_GREEN;
            8'd3:    return MASK_RED;
            8'd4:    return MASK_ALL;
            default: return MASK_NONE;
        endcase
    endfunction

    function automatic logic [31:0] reg_readback(input logic [mfdf_pkg::ADDR_W-1:0] addr);
        if (addr == ADDR_MOTOR_NUMBER) begin
            return {24'd0, motor_num};
        end
        return {21'd0, id_base};
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at word %0d: %s got 0x%0h expected 0x%0h",
                 word_index, what, got, want);
        fail_total++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic decode_frame(input logic [10:0] ident, input logic [15:0] angle,
                                input logic [15:0] speed, input logic [15:0] current,
                                input logic [7:0] temp, output t_decoded r);
        logic [10:0] offset;
        logic [63:0] angle_prod;
        longint      speed_q;
        longint      acc;
        offset = ident - id_base;
        r = '0;
        r.frame_matched = (offset[7:0] == motor_num);
        if (r.frame_matched) begin
            match_count  = match_count + 9'd1;
            held_angle   = angle;
            held_speed   = speed;
            held_current = current;
            held_temp    = temp;
        end
        if (match_count == mfdf_pkg::TOGGLE_PERIOD) begin
            match_count = '0;
            r.indicator_toggle = toggle_mask(motor_num);
        end
        angle_prod = 64'(held_angle) * mfdf_pkg::PI_Q46 + mfdf_pkg::ANGLE_ROUND;
        speed_q = longint'(held_speed) * 2560;
        if (motor_num < mfdf_pkg::MOTOR_COUNT) begin
            acc = 64'sd13107 * longint'(filt_speed) + 64'sd52429 * speed_q + 64'sd32768;
            filt_speed = 28'(acc >>> 16);
            r.speed_radps = filt_speed;
        end else begin
            r.speed_radps = 28'(speed_q);
        end
        r.angle_raw     = held_angle;
        r.speed_raw     = held_speed;
        r.current_raw   = held_current;
        r.temperature   = held_temp;
        r.angle_radians = angle_prod[63:42];
    endtask

    always @(posedge i_clk) begin : monitor
        t_decoded want;
        t_decoded got;
        if (!i_rst_n) begin
            motor_num    = mfdf_pkg::MOTOR_NUMBER_RESET;
            id_base      = mfdf_pkg::ID_BASE_RESET;
            held_angle   = '0;
            held_speed   = '0;
            held_current = '0;
            held_temp    = '0;
            match_count  = '0;
            filt_speed   = '0;
            fail_total   = 0;
            word_index   = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_MOTOR_NUMBER) begin
                        motor_num = pwdata[7:0];
                    end else if (paddr == ADDR_ID_BASE) begin
                        id_base = pwdata[10:0];
                    end
                end else begin
                    check_field("register readback", prdata, reg_readback(paddr));
                end
            end
            if (i_frame.valid && i_frame.ready) begin
                decode_frame(i_frame.frame_ident, {i_frame.byte0, i_frame.byte1},
                             {i_frame.byte2, i_frame.byte3}, {i_frame.byte4, i_frame.byte5},
                             i_frame.byte6, want);
                expected_q.push_back(want);
            end
            if (i_result.valid && i_result.ready) begin
                got.frame_matched    = i_result.frame_matched;
                got.angle_raw        = i_result.angle_raw;
                got.speed_raw        = i_result.speed_raw;
                got.current_raw      = i_result.current_raw;
                got.temperature      = i_result.temperature;
                got.angle_radians    = i_result.angle_radians;
                got.speed_radps      = i_result.speed_radps;
                got.indicator_toggle = i_result.indicator_toggle;
                if (expected_q.size() == 0) begin
                    report_mismatch("word with nothing expected, angle_raw", got.angle_raw, 0);
                end else begin
                    want = expected_q.pop_front();
                    check_field("frame_matched", got.frame_matched, want.frame_matched);
                    check_field("angle_raw", got.angle_raw, want.angle_raw);
                    check_field("speed_raw", got.speed_raw, want.speed_raw);
                    check_field("current_raw", got.current_raw, want.current_raw);
                    check_field("temperature", got.temperature, want.temperature);
                    check_field("angle_radians", got.angle_radians, want.angle_radians);
                    check_field("speed_radps", got.speed_radps, want.speed_radps);
                    check_field("indicator_toggle", got.indicator_toggle,
                                want.indicator_toggle);
                end
                word_index++;
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback decoder testbench
// Sends directed and random feedback frames in bursts, walks the motor number
// and identifier base through several settings between phases, stalls the
// result side on its own pattern and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [mfdf_pkg::ADDR_W-1:0] ADDR_MOTOR_NUMBER =
        {mfdf_pkg::REG_MOTOR_NUMBER, 2'b00};
    localparam logic [mfdf_pkg::ADDR_W-1:0] ADDR_ID_BASE =
        {mfdf_pkg::REG_ID_BASE, 2'b00};

    typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    typedef struct packed {
        logic [10:0] ident;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
        logic [7:0]  temp;
    } t_frame;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [mfdf_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          fail_count;
    int                          pending;

    logic [7:0]  cur_motor;
    logic [10:0] cur_base;
    int          match_tally;
    bit          toggle_wrapped;
    int          burst_left;
    bit          hold_request;
    int          idle_cycles;

    mfdf_frame_if  frame_bus ();
    mfdf_result_if result_bus ();

    motor_feedback_decode_filter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mfdf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame_bus),
        .i_result     (result_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    function automatic t_frame make_frame(input logic [10:0] ident, input logic [15:0] angle,
                                          input logic [15:0] speed, input logic [15:0] current,
                                          input logic [7:0] temp);
        t_frame f;
        f.ident   = ident;
        f.angle   = angle;
        f.speed   = speed;
        f.current = current;
        f.temp    = temp;
        return f;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic apb_access(input bit write, input logic [mfdf_pkg::ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] motor, input logic [10:0] base);
        logic [31:0] data;
        data = $urandom();
        data[7:0] = motor;
        apb_access(1'b1, ADDR_MOTOR_NUMBER, data);
        data = $urandom();
        data[10:0] = base;
        apb_access(1'b1, ADDR_ID_BASE, data);
        apb_access(1'b0, ADDR_MOTOR_NUMBER, 32'd0);
        apb_access(1'b0, ADDR_ID_BASE, 32'd0);
        cur_motor = motor;
        cur_base  = base;
    endtask

    task automatic offer_frame(input t_frame f);
        int          gap;
        logic [10:0] offset;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                frame_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        frame_bus.frame_ident <= f.ident;
        frame_bus.byte0       <= f.angle[15:8];
        frame_bus.byte1       <= f.angle[7:0];
        frame_bus.byte2       <= f.speed[15:8];
        frame_bus.byte3       <= f.speed[7:0];
        frame_bus.byte4       <= f.current[15:8];
        frame_bus.byte5       <= f.current[7:0];
        frame_bus.byte6       <= f.temp;
        frame_bus.valid       <= 1'b1;
        @(posedge i_clk);
        while (!frame_bus.ready) @(posedge i_clk);
        offset = f.ident - cur_base;
        if (offset[7:0] == cur_motor) begin
            match_tally++;
            if (match_tally == mfdf_pkg::TOGGLE_PERIOD) begin
                match_tally    = 0;
                toggle_wrapped = 1'b1;
            end
        end
    endtask

    task automatic drain_results();
        frame_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // Reset configuration: motor 1 on base 512.
        offer_frame(make_frame(11'd513, 16'h0000, 16'h0000, 16'h0000, 8'h00));
        offer_frame(make_frame(11'd513, 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF));
        offer_frame(make_frame(11'd769, 16'h0000, 16'h8000, 16'h8000, 8'h00));
        offer_frame(make_frame(11'd512, 16'h1234, 16'h5678, 16'h9ABC, 8'h5A));
        offer_frame(make_frame(11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        // Identifier below the base still matches through the modulo.
        offer_frame(make_frame(11'd1, 16'h8000, 16'h0001, 16'hFFFF, 8'h80));
        offer_frame(make_frame(11'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF));
        repeat (4) offer_frame(make_frame(11'd1793, 16'h0001, 16'h8000, 16'h8000, 8'h7F));
        repeat (4) offer_frame(make_frame(11'd257, 16'h7FFF, 16'h7FFF, 16'h0001, 8'h01));
        offer_frame(make_frame(11'd1025, 16'h0C91, 16'hFFFF, 16'h0000, 8'h40));
        offer_frame(make_frame(11'd1281, 16'h4000, 16'h0001, 16'h8000, 8'hC0));
        offer_frame(make_frame(11'd1537, 16'hAAAA, 16'h5555, 16'h5555, 8'hAA));
    endtask

    task automatic run_phase(input logic [7:0] motor, input logic [10:0] base,
                             input int min_items, input bit to_wrap, input int match_pct);
        int     n;
        t_frame f;
        drain_results();
        set_config(motor, base);
        toggle_wrapped = 1'b0;
        n = 0;
        while (n < min_items || (to_wrap && !toggle_wrapped)) begin
            if ($urandom_range(1, 100) <= match_pct) begin
                f.ident = cur_base + {3'($urandom_range(0, 7)), cur_motor};
            end else begin
                f.ident = 11'($urandom());
            end
            f.angle   = pick_word();
            f.speed   = pick_word();
            f.current = pick_word();
            f.temp    = 8'($urandom());
            offer_frame(f);
            n++;
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        frame_bus.valid       = 1'b0;
        frame_bus.frame_ident = '0;
        frame_bus.byte0       = '0;
        frame_bus.byte1       = '0;
        frame_bus.byte2       = '0;
        frame_bus.byte3       = '0;
        frame_bus.byte4       = '0;
        frame_bus.byte5       = '0;
        frame_bus.byte6       = '0;
        cur_motor             = mfdf_pkg::MOTOR_NUMBER_RESET;
        cur_base              = mfdf_pkg::ID_BASE_RESET;
        match_tally           = 0;
        toggle_wrapped        = 1'b0;
        burst_left            = 0;
        hold_request          = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, ADDR_MOTOR_NUMBER, 32'd0);
        apb_access(1'b0, ADDR_ID_BASE, 32'd0);
        run_directed();
        drain_results();

        hold_request = 1'b1;
        run_phase(8'd4, 11'($urandom()), 20, 1'b1, 97);
        run_phase(8'd0, 11'd0, 60, 1'b0, 80);
        run_phase(8'd7, 11'd2047, 60, 1'b0, 80);
        run_phase(8'd8, 11'($urandom()), 60, 1'b0, 80);
        run_phase(8'd1, 11'($urandom()), 20, 1'b1, 97);
        run_phase(8'd255, 11'd2047, 60, 1'b0, 80);
        run_phase(8'd2, 11'($urandom()), 60, 1'b0, 80);
        run_phase(8'd3, 11'd0, 60, 1'b0, 80);
        run_phase(8'($urandom()), 11'($urandom()), 60, 1'b0, 70);
        run_phase(8'($urandom_range(0, 7)), 11'($urandom()), 60, 1'b0, 85);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        int          seg_left;
        t_stall_mode mode;
        bit          held_off;
        result_bus.ready = 1'b0;
        seg_left = 0;
        mode     = STALL_NONE;
        held_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !held_off) begin
                held_off = 1'b1;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 60);
                    mode     = t_stall_mode'($urandom_range(0, 3));
                end
                seg_left--;
                case (mode)
                    STALL_NONE:  result_bus.ready <= 1'b1;
                    STALL_HALF:  result_bus.ready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: result_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:     result_bus.ready <= ~result_bus.ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (frame_bus.valid && frame_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: motor_feedback_decode_filter.f
+incdir+sv
sv/mfdf_pkg.sv
sv/mfdf_frame_if.sv
sv/mfdf_result_if.sv
sv/mfdf_regs.sv
sv/mfdf_core.sv
sv/mfdf_out.sv
sv/motor_feedback_decode_filter.sv
sv/mfdf_checker.sv
tb/sv/mfdf_checker.sv
tb/sv/tb.sv
